FILE: rtl/core/tet_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer expiry table package
// Shared types, operation and result codes for the timer expiry table.
// ----------------------------------------------------------------------------
package tet_pkg;

  localparam int MaxTimersDef = 32;
  localparam int SlotW        = 6;   // slot index width, covers up to 64 slots
  localparam int NowW         = 40;
  localparam int DlW          = 41;
  localparam int TimeoutW     = 31;

  localparam logic [2:0] FuncArm    = 3'd0;
  localparam logic [2:0] FuncRearm  = 3'd1;
  localparam logic [2:0] FuncCancel = 3'd2;
  localparam logic [2:0] FuncDrop   = 3'd3;
  localparam logic [2:0] FuncTick   = 3'd4;
  localparam logic [2:0] FuncQuery  = 3'd5;
  localparam logic [2:0] FuncClear  = 3'd6;

  localparam logic [1:0] KindExpired   = 2'd0;
  localparam logic [1:0] KindCancelled = 2'd1;
  localparam logic [1:0] KindReport    = 2'd2;

  localparam logic [31:0] RemMax  = 32'h7FFF_FFFF;
  localparam logic [31:0] RemNone = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [2:0]          func;
    logic [4:0]          timer_id;
    logic [TimeoutW-1:0] timeout_ms;
    logic [NowW-1:0]     now_ms;
  } tet_req_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [4:0]         fired_id;
    logic signed [31:0] remaining_ms;
    logic               last;
  } tet_rsp_t;

  // One slot as it comes out of the deadline memory
  typedef struct packed {
    logic             vld;
    logic [SlotW-1:0] id;
    logic [DlW-1:0]   dl;
  } tet_smp_t;

  // Running earliest slot of a scan pass
  typedef struct packed {
    logic             found;
    logic [SlotW-1:0] id;
    logic [DlW-1:0]   dl;
    logic             due;
  } tet_best_t;

endpackage

FILE: rtl/core/tet_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tet_ram #(
  parameter int Width = tet_pkg::DlW,
  parameter int Depth = tet_pkg::MaxTimersDef
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/tet_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Earliest-deadline scan unit
// Compares one slot per cycle against the running minimum of a pass.
// ----------------------------------------------------------------------------
module tet_scan (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           clr_i,
  input  tet_pkg::tet_smp_t              smp_i,
  input  logic [tet_pkg::NowW-1:0]       now_i,
  output tet_pkg::tet_best_t             best_o
);

  logic                        found_q, found_d;
  logic [tet_pkg::SlotW-1:0]   id_q, id_d;
  logic [tet_pkg::DlW-1:0]     dl_q, dl_d;
  logic                        take;

  // Strictly less keeps the lower id on equal deadlines (ids arrive ascending)
  assign take = smp_i.vld && (!found_q || (smp_i.dl < dl_q));

  always_comb begin
    found_d = found_q;
    id_d    = id_q;
    dl_d    = dl_q;
    if (clr_i) begin
      found_d = 1'b0;
    end else if (take) begin
      found_d = 1'b1;
      id_d    = smp_i.id;
      dl_d    = smp_i.dl;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else begin
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q <= id_d;
    dl_q <= dl_d;
  end

  assign best_o.found = found_q;
  assign best_o.id    = id_q;
  assign best_o.dl    = dl_q;
  assign best_o.due   = found_q && (dl_q <= {1'b0, now_i});

endmodule

FILE: rtl/core/timer_expiry_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Timer expiry table
// One-shot timers per id with expiry reporting in deadline order.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on req_valid_i/req_ready_o with payload req_i (func,
//   timer_id, timeout_ms, now_ms). Results leave on rsp_valid_o/rsp_ready_i
//   with payload rsp_o (kind, fired_id, remaining_ms, last); last marks the
//   final result of a request.
//   Arm, rearm and clear finish in the accepting cycle. Cancel passes through
//   the emit state and may wait for the output register.
//   Drop, tick and query run scan passes over the deadline RAM: one slot is
//   read per cycle and fed to the shared compare unit, and each pass ends in
//   a decide step. A tick or query that expires k timers runs k + 1 passes,
//   plus an emit step per result.
//   req_ready_o is high only while no request is in flight.
//   Reset disarms every slot and empties the output register; the deadline
//   RAM is not cleared, since only armed slots are ever looked at.
//   A stalled receiver holds the result in the output register and stalls
//   the sequencer at its next result; no result is lost or repeated.
// ----------------------------------------------------------------------------
module timer_expiry_table #(
  parameter int MAX_TIMERS = tet_pkg::MaxTimersDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  tet_pkg::tet_req_t req_i,
  output logic              rsp_valid_o,
  input  logic              rsp_ready_i,
  output tet_pkg::tet_rsp_t rsp_o
);

  localparam int IdxW = $clog2(MAX_TIMERS);
  localparam int CntW = $clog2(MAX_TIMERS + 1);

  // Sequencer states
  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StScan   = 2'd1;
  localparam logic [1:0] StDecide = 2'd2;
  localparam logic [1:0] StEmit   = 2'd3;

  logic [1:0]              state_q, state_d;
  logic [1:0]              ret_q, ret_d;
  tet_pkg::tet_req_t       req_q, req_d;
  logic [CntW-1:0]         cnt_q, cnt_d;
  logic                    rd_vld_q, rd_vld_d;
  logic [IdxW-1:0]         rd_idx_q, rd_idx_d;
  logic [MAX_TIMERS-1:0]   armed_q, armed_d;
  logic                    pend_vld_q, pend_vld_d;
  logic [4:0]              pend_id_q, pend_id_d;
  tet_pkg::tet_rsp_t       stg_q, stg_d;
  logic                    rsp_vld_q, rsp_vld_d;
  tet_pkg::tet_rsp_t       rsp_q, rsp_d;

  logic                    accept;
  logic                    id_ok;
  logic [IdxW-1:0]         id_idx;
  logic [IdxW-1:0]         best_idx;
  logic [tet_pkg::DlW-1:0] sum;
  logic [tet_pkg::DlW-1:0] diff;
  logic [31:0]             rem;
  logic                    ram_we;
  logic [tet_pkg::DlW-1:0] ram_rdata;
  logic                    scan_clr;
  tet_pkg::tet_smp_t       smp;
  tet_pkg::tet_best_t      best;

  assign req_ready_o = (state_q == StIdle);
  assign accept      = req_valid_i && req_ready_o;
  assign id_ok       = (32'(req_i.timer_id) < 32'(MAX_TIMERS));
  assign id_idx      = IdxW'(req_i.timer_id);
  assign best_idx    = IdxW'(best.id);
  assign sum         = {1'b0, req_i.now_ms} + tet_pkg::DlW'(req_i.timeout_ms);

  // Arm writes any valid id, rearm only an armed slot
  assign ram_we = accept && id_ok &&
                  ((req_i.func == tet_pkg::FuncArm) ||
                   ((req_i.func == tet_pkg::FuncRearm) && armed_q[id_idx]));

  tet_ram #(
    .Width (tet_pkg::DlW),
    .Depth (MAX_TIMERS)
  ) u_dl_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (id_idx),
    .wdata_i (sum),
    .raddr_i (cnt_q[IdxW-1:0]),
    .rdata_o (ram_rdata)
  );

  // Read data lines up with the slot index issued in the previous cycle
  assign smp.vld = rd_vld_q && armed_q[rd_idx_q];
  assign smp.id  = tet_pkg::SlotW'(rd_idx_q);
  assign smp.dl  = ram_rdata;

  tet_scan u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .clr_i  (scan_clr),
    .smp_i  (smp),
    .now_i  (req_q.now_ms),
    .best_o (best)
  );

  // Time left to the earliest deadline; it lies beyond now once all due timers have fired
  assign diff = best.dl - {1'b0, req_q.now_ms};
  always_comb begin
    if (!best.found) begin
      rem = tet_pkg::RemNone;
    end else if (diff > tet_pkg::DlW'(tet_pkg::RemMax)) begin
      rem = tet_pkg::RemMax;
    end else begin
      rem = diff[31:0];
    end
  end

  always_comb begin
    state_d    = state_q;
    ret_d      = ret_q;
    req_d      = req_q;
    cnt_d      = cnt_q;
    rd_vld_d   = 1'b0;
    rd_idx_d   = rd_idx_q;
    armed_d    = armed_q;
    pend_vld_d = pend_vld_q;
    pend_id_d  = pend_id_q;
    stg_d      = stg_q;
    scan_clr   = 1'b0;
    // Drop the held result once the receiver takes it
    rsp_vld_d  = rsp_vld_q && !rsp_ready_i;
    rsp_d      = rsp_q;

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          req_d = req_i;
          unique case (req_i.func) inside
            tet_pkg::FuncArm: begin
              if (id_ok) begin
                armed_d[id_idx] = 1'b1;
              end
            end
            tet_pkg::FuncCancel: begin
              if (id_ok && armed_q[id_idx]) begin
                armed_d[id_idx]    = 1'b0;
                stg_d.kind         = tet_pkg::KindCancelled;
                stg_d.fired_id     = req_i.timer_id;
                stg_d.remaining_ms = '0;
                stg_d.last         = 1'b1;
                ret_d              = StIdle;
                state_d            = StEmit;
              end
            end
            tet_pkg::FuncDrop, tet_pkg::FuncTick, tet_pkg::FuncQuery: begin
              cnt_d    = '0;
              scan_clr = 1'b1;
              state_d  = StScan;
            end
            tet_pkg::FuncClear: begin
              armed_d = '0;
            end
            default: begin
              // Rearm writes the RAM only; unknown codes do nothing
            end
          endcase
        end
      end

      StScan: begin
        if (cnt_q != CntW'(MAX_TIMERS)) begin
          rd_vld_d = 1'b1;
          rd_idx_d = cnt_q[IdxW-1:0];
          cnt_d    = cnt_q + CntW'(1);
        end else if (!rd_vld_q) begin
          state_d = StDecide;
        end
      end

      StDecide: begin
        if (req_q.func == tet_pkg::FuncDrop) begin
          if (best.found) begin
            armed_d[best_idx] = 1'b0;
          end
          state_d = StIdle;
        end else if (best.due) begin
          // Disarm and hold the new expiry until we know whether it is last
          armed_d[best_idx] = 1'b0;
          pend_vld_d        = 1'b1;
          pend_id_d         = 5'(best.id);
          cnt_d             = '0;
          scan_clr          = 1'b1;
          if (pend_vld_q) begin
            stg_d.kind         = tet_pkg::KindExpired;
            stg_d.fired_id     = pend_id_q;
            stg_d.remaining_ms = '0;
            stg_d.last         = 1'b0;
            ret_d              = StScan;
            state_d            = StEmit;
          end else begin
            state_d = StScan;
          end
        end else if (pend_vld_q) begin
          // Flush the held expiry; a query returns here for its report
          pend_vld_d         = 1'b0;
          stg_d.kind         = tet_pkg::KindExpired;
          stg_d.fired_id     = pend_id_q;
          stg_d.remaining_ms = '0;
          stg_d.last         = (req_q.func == tet_pkg::FuncTick);
          ret_d              = (req_q.func == tet_pkg::FuncTick) ? StIdle : StDecide;
          state_d            = StEmit;
        end else if (req_q.func == tet_pkg::FuncQuery) begin
          stg_d.kind         = tet_pkg::KindReport;
          stg_d.fired_id     = '0;
          stg_d.remaining_ms = rem;
          stg_d.last         = 1'b1;
          ret_d              = StIdle;
          state_d            = StEmit;
        end else begin
          state_d = StIdle;
        end
      end

      StEmit: begin
        // Hold the staged result until the output register is free
        if (!rsp_vld_q || rsp_ready_i) begin
          rsp_vld_d = 1'b1;
          rsp_d     = stg_q;
          state_d   = ret_q;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      ret_q      <= StIdle;
      cnt_q      <= '0;
      rd_vld_q   <= 1'b0;
      armed_q    <= '0;
      pend_vld_q <= 1'b0;
      rsp_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      ret_q      <= ret_d;
      cnt_q      <= cnt_d;
      rd_vld_q   <= rd_vld_d;
      armed_q    <= armed_d;
      pend_vld_q <= pend_vld_d;
      rsp_vld_q  <= rsp_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    rd_idx_q  <= rd_idx_d;
    pend_id_q <= pend_id_d;
    stg_q     <= stg_d;
    rsp_q     <= rsp_d;
  end

  assign rsp_valid_o = rsp_vld_q;
  assign rsp_o       = rsp_q;

  // The slot chosen by a finished pass is still armed
  a_best_armed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDecide) && best.found |-> armed_q[best_idx])
    else $error("scan picked a disarmed slot");

  // No expiry is left held once a request completes
  a_pend_empty_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle) |-> !pend_vld_q)
    else $error("held expiry left behind at idle");

  // An expiry disarms exactly one slot
  a_fire_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDecide) && (req_q.func != tet_pkg::FuncDrop) && best.due |=>
    ($countones(armed_q) + 1 == $countones($past(armed_q))))
    else $error("expiry did not disarm exactly one slot");

endmodule
